>>> rtl/core/amcf_pkg.sv
// Shared types, constants and the CRC-16 byte update for the arm motor framer.
// No dependencies.
package amcf_pkg;

  localparam int QUEUE_DEPTH  = 2;
  localparam int CFG_AW       = 3;
  localparam int PKT_BYTES    = 5;
  localparam int RUN_BYTES    = 2 * PKT_BYTES;

  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_TOP   = 16'h8000;
  localparam logic [7:0]  ADDR_RST  = 8'h80;
  localparam logic [6:0]  SPEED_MAX = 7'd127;
  localparam logic [6:0]  FSPD_RST  = 7'd127;

  localparam logic [7:0]  OP_M1_FWD = 8'd0;
  localparam logic [7:0]  OP_M1_BWD = 8'd1;
  localparam logic [7:0]  OP_M2_FWD = 8'd4;
  localparam logic [7:0]  OP_M2_BWD = 8'd5;

  localparam logic REG_DEV_ADDR = 1'b0;
  localparam logic REG_FIX_SPD  = 1'b1;

  typedef enum logic [2:0] {
    CMD_STOP       = 3'd0,
    CMD_BOTH_UP    = 3'd1,
    CMD_BOTH_DOWN  = 3'd2,
    CMD_FRONT_UP   = 3'd3,
    CMD_FRONT_DOWN = 3'd4,
    CMD_BACK_UP    = 3'd5,
    CMD_BACK_DOWN  = 3'd6,
    CMD_MOVE       = 3'd7
  } cmd_t;

  typedef struct packed {
    logic       bwd1;
    logic [6:0] spd1;
    logic       bwd2;
    logic [6:0] spd2;
  } motor_req_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> rtl/core/amcf_front.sv
// Front end: takes commands and turns them into per-motor direction and speed.
// Depends on amcf_pkg.
module amcf_front import amcf_pkg::*; (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_cmd,
  input  logic signed [15:0] in_arm_speed,
  input  logic [6:0]        fixed_speed,
  input  logic              q_full,
  output logic              q_push,
  output motor_req_t        q_data
);

  logic signed [15:0] neg_spd;
  logic [6:0]         mv_mag;
  logic               mv_bwd;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign neg_spd  = -in_arm_speed;

  always_comb begin
    if (in_arm_speed > 16'sd127) begin
      mv_mag = SPEED_MAX;
      mv_bwd = 1'b0;
    end else if (in_arm_speed < -16'sd127) begin
      mv_mag = SPEED_MAX;
      mv_bwd = 1'b1;
    end else if (in_arm_speed < 16'sd0) begin
      mv_mag = neg_spd[6:0];
      mv_bwd = 1'b1;
    end else begin
      mv_mag = in_arm_speed[6:0];
      mv_bwd = 1'b0;
    end
  end

  always_comb begin
    q_data = '0;
    unique case (cmd_t'(in_cmd))
      CMD_STOP: ;
      CMD_BOTH_UP: begin
        q_data.spd1 = fixed_speed;
        q_data.spd2 = fixed_speed;
      end
      CMD_BOTH_DOWN: begin
        q_data.spd1 = fixed_speed;
        q_data.spd2 = fixed_speed;
        q_data.bwd1 = 1'b1;
        q_data.bwd2 = 1'b1;
      end
      CMD_FRONT_UP: q_data.spd1 = fixed_speed;
      CMD_FRONT_DOWN: begin
        q_data.spd1 = fixed_speed;
        q_data.bwd1 = 1'b1;
      end
      CMD_BACK_UP: q_data.spd2 = fixed_speed;
      CMD_BACK_DOWN: begin
        q_data.spd2 = fixed_speed;
        q_data.bwd2 = 1'b1;
      end
      CMD_MOVE: begin
        q_data.spd1 = mv_mag;
        q_data.spd2 = mv_mag;
        q_data.bwd1 = mv_bwd;
        q_data.bwd2 = mv_bwd;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/amcf_queue.sv
// Short show-ahead queue of motor requests between front and back ends.
// Depends on amcf_pkg.
module amcf_queue import amcf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  motor_req_t wr_data,
  input  logic       pop,
  output motor_req_t rd_data,
  output logic       full,
  output logic       empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  motor_req_t    mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == LAST) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == LAST) ? '0 : rp_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

>>> rtl/core/amcf_back.sv
// Back end: takes requests from the queue head and hands them to the byte
// serialiser. Depends on amcf_pkg and amcf_serial.
module amcf_back import amcf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] dev_addr,
  input  motor_req_t req,
  input  logic       req_avail,
  output logic       req_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_tx_byte,
  output logic       out_last_byte
);

  amcf_serial u_serial (
    .clk           (clk),
    .rst_n         (rst_n),
    .dev_addr      (dev_addr),
    .req           (req),
    .req_avail     (req_avail),
    .req_pop       (req_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tx_byte   (out_tx_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

>>> rtl/core/amcf_serial.sv
// Back end: serialises each request into two framed packets with CRC-16.
// Depends on amcf_pkg.
module amcf_serial import amcf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] dev_addr,
  input  motor_req_t req,
  input  logic       req_avail,
  output logic       req_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_tx_byte,
  output logic       out_last_byte
);

  localparam int IW = $clog2(RUN_BYTES);
  localparam logic [IW-1:0] IDX_LAST = IW'(RUN_BYTES - 1);

  logic [IW-1:0] idx_r, idx_nxt;
  logic [15:0]   crc_r, crc_in;
  logic [7:0]    byte_sel;
  logic          valid_r, last_r, load, second, first_of_pkt, crc_upd;
  logic [7:0]    tx_r;

  assign load      = req_avail && (!valid_r || !out_stall);
  assign req_pop   = load && (idx_r == IDX_LAST);
  assign idx_nxt   = (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
  assign second    = (idx_r >= IW'(PKT_BYTES));

  always_comb begin
    byte_sel     = 8'h00;
    first_of_pkt = 1'b0;
    crc_upd      = 1'b0;
    unique case (second ? idx_r - IW'(PKT_BYTES) : idx_r)
      IW'(0): begin
        byte_sel     = dev_addr;
        first_of_pkt = 1'b1;
        crc_upd      = 1'b1;
      end
      IW'(1): begin
        if (second) byte_sel = req.bwd2 ? OP_M2_BWD : OP_M2_FWD;
        else        byte_sel = req.bwd1 ? OP_M1_BWD : OP_M1_FWD;
        crc_upd = 1'b1;
      end
      IW'(2): begin
        byte_sel = {1'b0, second ? req.spd2 : req.spd1};
        crc_upd  = 1'b1;
      end
      IW'(3): byte_sel = crc_r[15:8];
      IW'(4): byte_sel = crc_r[7:0];
      default: byte_sel = 8'h00;
    endcase
  end

  assign crc_in = first_of_pkt ? 16'h0000 : crc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r   <= idx_nxt;
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tx_r   <= byte_sel;
      last_r <= (idx_r == IDX_LAST);
      if (crc_upd) crc_r <= crc_byte(crc_in, byte_sel);
    end
  end

  assign out_valid     = valid_r;
  assign out_tx_byte   = tx_r;
  assign out_last_byte = last_r;

endmodule

>>> rtl/core/arm_motor_command_framer.sv
// Top level of the arm motor command framer: register port, front end,
// request queue and serialiser. Depends on amcf_pkg and the amcf_* modules.
//
// Usage:
//  - Input channel (in_valid/in_stall, in_cmd, in_arm_speed) takes one arm
//    command per request. in_stall rises only when the request queue is full.
//  - Output channel (out_valid/out_stall, out_tx_byte, out_last_byte) gives
//    ten bytes per command: motor 1 packet then motor 2 packet, each
//    address, opcode, speed, CRC high, CRC low. out_last_byte marks byte ten.
//  - Throughput: one byte per cycle while a command is queued and the
//    receiver does not stall; the one-byte output channel sets that rate.
//  - The first byte passes the queue, then the serialiser output register.
//  - The CRC takes each packet's first three bytes, one per unstalled cycle.
//  - Registers: address 0 device address (reset 0x80), address 4 fixed
//    speed (reset 127). Write them only while the block is idle.
//  - Reset clears the queue and the serialiser; no bytes are pending.
//  - When the receiver stalls the output byte holds; the queue keeps taking
//    commands until it fills.
module arm_motor_command_framer import amcf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_cmd,
  input  logic signed [15:0] in_arm_speed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_tx_byte,
  output logic               out_last_byte
);

  logic [7:0] dev_addr_r;
  logic [6:0] fix_spd_r;
  logic       wr_en;
  motor_req_t push_data, head;
  logic       q_push, q_pop, q_full, q_empty;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= ADDR_RST;
      fix_spd_r  <= FSPD_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_DEV_ADDR: dev_addr_r <= pwdata[7:0];
        REG_FIX_SPD:  fix_spd_r  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DEV_ADDR: prdata = {24'h0, dev_addr_r};
      REG_FIX_SPD:  prdata = {25'h0, fix_spd_r};
      default:      prdata = 32'h0;
    endcase
  end

  amcf_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_arm_speed (in_arm_speed),
    .fixed_speed  (fix_spd_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (push_data)
  );

  amcf_queue #(.DEPTH(DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (push_data),
    .pop     (q_pop),
    .rd_data (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  amcf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .dev_addr      (dev_addr_r),
    .req           (head),
    .req_avail     (!q_empty),
    .req_pop       (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tx_byte   (out_tx_byte),
    .out_last_byte (out_last_byte)
  );

endmodule
